// File: sv/lbbt_pkg.sv
// Shared types and constants of the label bounding box tracker.
`default_nettype none

package lbbt_pkg;

    // Parameter defaults
    localparam int MAX_FEATURES_DEF = 4096;
    localparam int COORD_BITS_DEF   = 16;

    // Field widths fixed by the interface
    localparam int LABEL_BITS = 32;
    localparam int INDEX_BITS = 12;
    localparam int SIZE_BITS  = 16;
    localparam int FCNT_BITS  = 13;

    // Commands carried by an item
    typedef enum logic [1:0] {
        CMD_VOXEL  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BG      = 2'd1,
        ST_RANGE   = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_X_SIZE = 2'd0,
        REG_Y_SIZE = 2'd1,
        REG_Z_SIZE = 2'd2,
        REG_FCOUNT = 2'd3
    } reg_idx_t;

    // Register reset values
    localparam logic [SIZE_BITS-1:0] SIZE_RST   = 16'd1;
    localparam logic [FCNT_BITS-1:0] FCOUNT_RST = 13'd4096;

    // Control from the item front end to the coordinate counters
    typedef struct packed {
        logic advance;
        logic restart;
    } coord_ctl_t;

endpackage

`default_nettype wire

// File: sv/lbbt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lbbt_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: sv/lbbt_coord.sv
// Voxel coordinate counters: x fastest, carrying into y then z.
`default_nettype none

module lbbt_coord #(
    parameter int COORD_BITS = lbbt_pkg::COORD_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lbbt_pkg::coord_ctl_t              ctl,
    input  wire logic [lbbt_pkg::SIZE_BITS-1:0]    x_size,
    input  wire logic [lbbt_pkg::SIZE_BITS-1:0]    y_size,
    input  wire logic [lbbt_pkg::SIZE_BITS-1:0]    z_size,
    output logic      [COORD_BITS-1:0]             col,
    output logic      [COORD_BITS-1:0]             row,
    output logic      [COORD_BITS-1:0]             slice
);

    logic [COORD_BITS-1:0] col_reg, row_reg, slice_reg;
    logic [COORD_BITS-1:0] col_inc, row_inc, slice_inc;
    logic [COORD_BITS-1:0] col_next, row_next, slice_next;
    logic                  col_wrap, row_wrap;

    // size of zero wraps at 2^COORD_BITS naturally
    always_comb
    begin
        col_inc   = col_reg + 1'b1;
        row_inc   = row_reg + 1'b1;
        slice_inc = slice_reg + 1'b1;
        col_wrap  = (col_inc == COORD_BITS'(x_size));
        row_wrap  = (row_inc == COORD_BITS'(y_size));
        col_next  = col_wrap ? '0 : col_inc;
        row_next  = row_reg;
        slice_next = slice_reg;
        if (col_wrap)
        begin
            row_next = row_wrap ? '0 : row_inc;
            if (row_wrap)
            begin
                slice_next = (slice_inc == COORD_BITS'(z_size)) ? '0 : slice_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            slice_reg <= '0;
        end
        else if (ctl.restart)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            slice_reg <= '0;
        end
        else if (ctl.advance)
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            slice_reg <= slice_next;
        end
    end

    assign col   = col_reg;
    assign row   = row_reg;
    assign slice = slice_reg;

endmodule

`default_nettype wire

// File: sv/label_bounding_box_tracker_top.sv
// Top level of the per-label 3D bounding box tracker.
// An accepted item passes through the stage 1 registers and then the output register.
// Throughput: one item per cycle for voxel, read and unused commands while the result channel does not stall.
// A clear item, and reset, start a sweep over all MAX_FEATURES entries of the corner
// RAM (one entry per cycle); no item is accepted during the sweep.
// Reset: asynchronous, active low; registers take their reset values, counters
// and the error flag clear, then the table sweep runs.
`default_nettype none

module label_bounding_box_tracker_top #(
    parameter int MAX_FEATURES = lbbt_pkg::MAX_FEATURES_DEF,
    parameter int COORD_BITS   = lbbt_pkg::COORD_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // configuration write channel
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [1:0]                            cfg_index,
    input  wire logic [lbbt_pkg::SIZE_BITS-1:0]        cfg_data,
    // item input channel
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [1:0]                            command,
    input  wire logic signed [lbbt_pkg::LABEL_BITS-1:0] label,
    input  wire logic [lbbt_pkg::INDEX_BITS-1:0]       entry_index,
    // result channel
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic      [1:0]                            status,
    output logic                                       error_latched,
    output logic      [COORD_BITS-1:0]                 low_x,
    output logic      [COORD_BITS-1:0]                 low_y,
    output logic      [COORD_BITS-1:0]                 low_z,
    output logic      [COORD_BITS-1:0]                 high_x,
    output logic      [COORD_BITS-1:0]                 high_y,
    output logic      [COORD_BITS-1:0]                 high_z
);

    localparam int AW = $clog2(MAX_FEATURES);
    localparam int CB = COORD_BITS;
    localparam int HW = 3 * CB;         // one corner (x, y, z)
    localparam int EW = 2 * HW;         // entry: {high corner, low corner}
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_FEATURES - 1);
    localparam logic [31:0]   MAXF32    = 32'(MAX_FEATURES);
    localparam logic [EW-1:0] CLEAR_ENTRY = {{HW{1'b0}}, {HW{1'b1}}};

    // ------------------------------------------------------------------
    // Configuration registers; the port never stalls.
    // ------------------------------------------------------------------
    logic [lbbt_pkg::SIZE_BITS-1:0] x_size_reg, y_size_reg, z_size_reg;
    logic [lbbt_pkg::FCNT_BITS-1:0] fcount_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_size_reg <= lbbt_pkg::SIZE_RST;
            y_size_reg <= lbbt_pkg::SIZE_RST;
            z_size_reg <= lbbt_pkg::SIZE_RST;
            fcount_reg <= lbbt_pkg::FCOUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                lbbt_pkg::REG_X_SIZE: x_size_reg <= cfg_data;
                lbbt_pkg::REG_Y_SIZE: y_size_reg <= cfg_data;
                lbbt_pkg::REG_Z_SIZE: z_size_reg <= cfg_data;
                lbbt_pkg::REG_FCOUNT: fcount_reg <= cfg_data[lbbt_pkg::FCNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control
    // stage 0: item accepted, status decided, RAM read issued
    // stage 1: RAM data back (with forwarding), min/max, write-back
    // output register: result held until taken
    // ------------------------------------------------------------------
    logic in_fire, s1_go;
    logic clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;
    logic s1_valid_reg, out_valid_reg;

    assign s1_go    = !out_valid_reg || out_ready;
    assign in_ready = !clr_busy_reg && (!s1_valid_reg || s1_go);
    assign in_fire  = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Stage 0 decode
    // ------------------------------------------------------------------
    logic                err_reg, err_next;
    logic [31:0]         fc32, lim32, lab_u, idx32;
    logic                lab_zero, lab_oor, idx_oor;
    lbbt_pkg::status_t   st0_status;
    logic                st0_upd, st0_rd, st0_oor_rd, st0_adv;
    logic [AW-1:0]       st0_addr;
    logic [CB-1:0]       col, row, slice;
    lbbt_pkg::coord_ctl_t coord_ctl;

    always_comb
    begin
        fc32     = 32'(fcount_reg);
        lim32    = (fc32 < MAXF32) ? fc32 : MAXF32;
        lab_u    = $unsigned(label);
        idx32    = 32'(entry_index);
        lab_zero = (lab_u == '0);
        lab_oor  = label[lbbt_pkg::LABEL_BITS-1] || (lab_u >= lim32);
        idx_oor  = (idx32 >= MAXF32);
    end

    always_comb
    begin
        st0_status = lbbt_pkg::ST_OK;
        st0_upd    = 1'b0;
        st0_rd     = 1'b0;
        st0_oor_rd = 1'b0;
        st0_adv    = 1'b0;
        st0_addr   = '0;
        err_next   = err_reg;
        case (command)
            lbbt_pkg::CMD_VOXEL:
            begin
                if (err_reg)
                begin
                    st0_status = lbbt_pkg::ST_IGNORED;
                end
                else if (lab_zero)
                begin
                    st0_status = lbbt_pkg::ST_BG;
                    st0_adv    = 1'b1;
                end
                else if (lab_oor)
                begin
                    st0_status = lbbt_pkg::ST_RANGE;
                    err_next   = 1'b1;
                end
                else
                begin
                    st0_upd  = 1'b1;
                    st0_adv  = 1'b1;
                    st0_addr = lab_u[AW-1:0];
                end
            end
            lbbt_pkg::CMD_READ:
            begin
                if (idx_oor)
                begin
                    st0_status = lbbt_pkg::ST_RANGE;
                    st0_oor_rd = 1'b1;
                end
                else
                begin
                    st0_rd   = 1'b1;
                    st0_addr = idx32[AW-1:0];
                end
            end
            lbbt_pkg::CMD_CLEAR:
            begin
                err_next = 1'b0;
            end
            default: ;
        endcase
    end

    // counters advance on an accepted voxel that is background or updates a box; a clear restarts them
    assign coord_ctl.advance = in_fire && st0_adv;
    assign coord_ctl.restart = in_fire && (command == lbbt_pkg::CMD_CLEAR);

    lbbt_coord #(
        .COORD_BITS (COORD_BITS)
    ) u_coord (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (coord_ctl),
        .x_size (x_size_reg),
        .y_size (y_size_reg),
        .z_size (z_size_reg),
        .col    (col),
        .row    (row),
        .slice  (slice)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            err_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            err_reg <= err_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 registers
    // ------------------------------------------------------------------
    lbbt_pkg::status_t s1_status_reg;
    logic              s1_err_reg, s1_upd_reg, s1_rd_reg, s1_oor_rd_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic [HW-1:0]     s1_pos_reg;

    // stage 1 empties when its item moves on, even while the input is closed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!s1_valid_reg || s1_go)
        begin
            s1_valid_reg <= in_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_status_reg <= st0_status;
            s1_err_reg    <= err_next;
            s1_upd_reg    <= st0_upd;
            s1_rd_reg     <= st0_rd;
            s1_oor_rd_reg <= st0_oor_rd;
            s1_addr_reg   <= st0_addr;
            s1_pos_reg    <= {slice, row, col};
        end
    end

    // ------------------------------------------------------------------
    // Corner RAM, clear sweep and forwarding
    // ------------------------------------------------------------------
    logic          ram_we, ram_re, upd_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata, ram_rdata;
    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    logic [EW-1:0] fwd_data_reg;
    logic [EW-1:0] entry, upd_entry, s1_res;

    assign upd_we    = s1_valid_reg && s1_go && s1_upd_reg;
    assign ram_we    = clr_busy_reg || upd_we;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : s1_addr_reg;
    assign ram_wdata = clr_busy_reg ? CLEAR_ENTRY : upd_entry;
    assign ram_re    = in_fire && (st0_upd || st0_rd);

    lbbt_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_FEATURES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (st0_addr),
        .rdata (ram_rdata)
    );

    // clear sweep, one entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (in_fire && (command == lbbt_pkg::CMD_CLEAR))
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_busy_reg <= (clr_addr_reg != LAST_ADDR);
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    // last write-back, covers a read issued at the edge of that write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (in_fire && (command == lbbt_pkg::CMD_CLEAR))
        begin
            fwd_valid_reg <= 1'b0;
        end
        else if (upd_we)
        begin
            fwd_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= upd_entry;
        end
    end

    assign entry = (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg)) ? fwd_data_reg : ram_rdata;

    // widen the box per axis: low corner in the lower half, high in the upper
    always_comb
    begin
        upd_entry = entry;
        for (int a = 0; a < 3; a++)
        begin
            if (s1_pos_reg[a*CB +: CB] < entry[a*CB +: CB])
            begin
                upd_entry[a*CB +: CB] = s1_pos_reg[a*CB +: CB];
            end
            if (s1_pos_reg[a*CB +: CB] > entry[HW + a*CB +: CB])
            begin
                upd_entry[HW + a*CB +: CB] = s1_pos_reg[a*CB +: CB];
            end
        end
    end

    // corners only on reads; a read past the table gives the never-hit pattern
    always_comb
    begin
        s1_res = '0;
        if (s1_rd_reg)
        begin
            s1_res = entry;
        end
        else if (s1_oor_rd_reg)
        begin
            s1_res = CLEAR_ENTRY;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    lbbt_pkg::status_t out_status_reg;
    logic              out_err_reg;
    logic [EW-1:0]     out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_valid_reg)
        begin
            out_status_reg <= s1_status_reg;
            out_err_reg    <= s1_err_reg;
            out_res_reg    <= s1_res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign error_latched = out_err_reg;
    assign low_x         = out_res_reg[0*CB +: CB];
    assign low_y         = out_res_reg[1*CB +: CB];
    assign low_z         = out_res_reg[2*CB +: CB];
    assign high_x        = out_res_reg[HW + 0*CB +: CB];
    assign high_y        = out_res_reg[HW + 1*CB +: CB];
    assign high_z        = out_res_reg[HW + 2*CB +: CB];

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // sweep and voxel write-back never share the write port
    a_no_upd_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !upd_we)
        else $error("voxel write-back during table sweep");

    // a clear starts the sweep and closes the input
    a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (command == lbbt_pkg::CMD_CLEAR)) |=> (clr_busy_reg && !in_ready))
        else $error("clear did not start the sweep");

    // a box update only happens while no error is latched
    a_upd_no_error: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_upd_reg) |-> !s1_err_reg)
        else $error("box update with error latched");

    // a stalled result is not overwritten by stage 1
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_res_reg)
            && $stable(out_status_reg)))
        else $error("stalled result changed");

endmodule

`default_nettype wire
